// File: sv/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg
// Shared sizes, codes and types of the LRU address-to-name cache.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int CAPACITY    = 256;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int HANDLE_BITS = 16;
    localparam int HVAL_W      = HANDLE_BITS + 1;
    localparam int ADDR_W      = 32;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 8;
    localparam int PERIOD_W    = 16;
    localparam int PRUNED_W    = 8;
    localparam int NPR_W       = 7;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // floor(x / 5) for x below 1024 as (x * 205) >> 10
    localparam int RECIP5      = 205;
    localparam int RECIP_SHIFT = 10;
    localparam int DIV_PROD_W  = 18;

    localparam logic [1:0] REG_SIZE_LIMIT = 2'd0;
    localparam logic [1:0] REG_TTL        = 2'd1;
    localparam logic [1:0] REG_PERIOD     = 2'd2;

    localparam logic OPC_LOOKUP = 1'b0;
    localparam logic OPC_INSERT = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic                   opcode;
        logic [ADDR_W-1:0]      ipv4_addr;
        logic [HANDLE_BITS-1:0] host_handle;
        logic                   name_resolved;
        logic [TIME_W-1:0]      now_seconds;
    } lac_req_t;

    typedef struct packed {
        logic                   hit;
        logic [HANDLE_BITS-1:0] found_handle;
        logic                   found_resolved;
        logic                   flushed;
        logic [PRUNED_W-1:0]    pruned_count;
        logic [CNT_W-1:0]       entry_count;
    } lac_rsp_t;

    typedef enum logic [1:0] {
        TGT_HOLD,
        TGT_MATCH,
        TGT_FREE,
        TGT_OLDEST
    } tgt_sel_t;

    typedef struct packed {
        logic     op_load;
        logic     ttl_check;
        logic     scan_start;
        logic     scan_en;
        tgt_sel_t tgt_sel;
        logic     link_rd;
        logic     unlink;
        logic     clear_valid;
        logic     push;
        logic     store_wr;
        logic     hit_latch;
        logic     prune_init;
        logic     pruned_inc;
        logic     n_dec;
        logic     out_load;
    } lac_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic scan_done;
        logic match_found;
        logic store_full;
        logic prune_need;
        logic prune_more;
        logic out_free;
    } lac_status_t;

endpackage

// File: sv/lac_if.sv
// ----------------------------------------------------------------------------
// lac_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface lac_req_if;
    import lac_pkg::*;

    logic     valid;
    logic     ready;
    lac_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lac_rsp_if;
    import lac_pkg::*;

    logic     valid;
    logic     ready;
    lac_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/lru_address_name_cache.sv
// ----------------------------------------------------------------------------
// lru_address_name_cache
// Fully associative IPv4-to-name-handle cache in LRU order, with sampled TTL
// flush and batch pruning of the oldest entries.
// Every request scans the whole store, one entry per cycle; a hit or a
// present key is relinked as newest, an insert into a full store evicts
// the oldest entry, and pruning removes further oldest entries.
// One word in flight; the next word is taken while a response waits.
// Reset is asynchronous and immediate: empty cache, registers at defaults.
// ----------------------------------------------------------------------------
module lru_address_name_cache (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lac_pkg::PADDR_W-1:0] paddr,
    input  logic [lac_pkg::PDATA_W-1:0] pwdata,
    output logic [lac_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    lac_req_if.sink                     req,
    lac_rsp_if.source                   rsp
);
    import lac_pkg::*;

    logic [LIMIT_W-1:0]  size_limit_reg;
    logic [TIME_W-1:0]   ttl_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [1:0]          reg_idx;
    logic                cfg_wr;
    lac_cmd_t            cmd;
    lac_status_t         st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00 || 1'b1);

    always_comb
    begin
        case (reg_idx)
            REG_SIZE_LIMIT: prdata = PDATA_W'(size_limit_reg);
            REG_TTL:        prdata = PDATA_W'(ttl_reg);
            REG_PERIOD:     prdata = PDATA_W'(period_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= LIMIT_W'(255);
            ttl_reg        <= TIME_W'(3600);
            period_reg     <= PERIOD_W'(1000);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SIZE_LIMIT: size_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_TTL:        ttl_reg        <= pwdata[TIME_W-1:0];
                REG_PERIOD:     period_reg     <= pwdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    lac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    lac_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .req_data      (req.data),
        .size_limit    (size_limit_reg),
        .ttl_seconds   (ttl_reg),
        .sample_period (period_reg),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_data      (rsp.data)
    );

endmodule

// File: sv/lac_ctrl.sv
// ----------------------------------------------------------------------------
// lac_ctrl
// Sequencer: TTL check, store scan, list relink, eviction and pruning.
// ----------------------------------------------------------------------------
module lac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lac_pkg::lac_status_t st,
    output lac_pkg::lac_cmd_t    cmd
);
    import lac_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_TTL    = 12'b0000_0000_0010,
        ST_SCAN   = 12'b0000_0000_0100,
        ST_LINKRD = 12'b0000_0000_1000,
        ST_UNLINK = 12'b0000_0001_0000,
        ST_EVRD   = 12'b0000_0010_0000,
        ST_EVICT  = 12'b0000_0100_0000,
        ST_PUSH   = 12'b0000_1000_0000,
        ST_PRCHK  = 12'b0001_0000_0000,
        ST_PRTEST = 12'b0010_0000_0000,
        ST_PRRD   = 12'b0100_0000_0000,
        ST_PRWR   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    assign req_ready = (state_reg == ST_IDLE) && !done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = done_reg;
        if (done_reg)
        begin
            if (st.out_free)
            begin
                cmd.out_load = 1'b1;
                done_next    = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd.op_load = 1'b1;
                        state_next  = ST_TTL;
                    end
                end
                ST_TTL:
                begin
                    cmd.ttl_check  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                ST_SCAN:
                begin
                    cmd.scan_en = 1'b1;
                    if (st.scan_done)
                    begin
                        if (st.match_found)
                        begin
                            cmd.tgt_sel = TGT_MATCH;
                            state_next  = ST_LINKRD;
                        end
                        else if (!st.is_insert)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (st.store_full)
                        begin
                            cmd.tgt_sel = TGT_OLDEST;
                            state_next  = ST_EVRD;
                        end
                        else
                        begin
                            cmd.tgt_sel = TGT_FREE;
                            state_next  = ST_PUSH;
                        end
                    end
                end
                ST_LINKRD:
                begin
                    cmd.link_rd = 1'b1;
                    state_next  = ST_UNLINK;
                end
                ST_UNLINK:
                begin
                    cmd.unlink    = 1'b1;
                    cmd.hit_latch = !st.is_insert;
                    state_next    = ST_PUSH;
                end
                ST_EVRD:
                begin
                    cmd.link_rd = 1'b1;
                    state_next  = ST_EVICT;
                end
                ST_EVICT:
                begin
                    cmd.unlink      = 1'b1;
                    cmd.clear_valid = 1'b1;
                    cmd.pruned_inc  = 1'b1;
                    state_next      = ST_PUSH;
                end
                ST_PUSH:
                begin
                    cmd.push     = 1'b1;
                    cmd.store_wr = st.is_insert;
                    if (st.is_insert)
                    begin
                        state_next = ST_PRCHK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                ST_PRCHK:
                begin
                    if (st.prune_need)
                    begin
                        cmd.prune_init = 1'b1;
                        state_next     = ST_PRTEST;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                ST_PRTEST:
                begin
                    if (st.prune_more)
                    begin
                        cmd.tgt_sel = TGT_OLDEST;
                        state_next  = ST_PRRD;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                ST_PRRD:
                begin
                    cmd.link_rd = 1'b1;
                    state_next  = ST_PRWR;
                end
                ST_PRWR:
                begin
                    cmd.unlink      = 1'b1;
                    cmd.clear_valid = 1'b1;
                    cmd.pruned_inc  = 1'b1;
                    cmd.n_dec       = 1'b1;
                    state_next      = ST_PRTEST;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: sv/lac_datapath.sv
// ----------------------------------------------------------------------------
// lac_datapath
// Entry stores, LRU links, TTL state, scan pipeline and response register.
// ----------------------------------------------------------------------------
module lac_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lac_pkg::lac_cmd_t                cmd,
    output lac_pkg::lac_status_t             st,
    input  lac_pkg::lac_req_t                req_data,
    input  logic [lac_pkg::LIMIT_W-1:0]      size_limit,
    input  logic [lac_pkg::TIME_W-1:0]       ttl_seconds,
    input  logic [lac_pkg::PERIOD_W-1:0]     sample_period,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output lac_pkg::lac_rsp_t                rsp_data
);
    import lac_pkg::*;

    logic [ADDR_W-1:0] key_mem   [CAPACITY];
    logic [HVAL_W-1:0] hdl_mem   [CAPACITY];
    slot_t             newer_mem [CAPACITY];
    slot_t             older_mem [CAPACITY];

    logic                   op_reg;
    logic [ADDR_W-1:0]      ip_reg;
    logic [HVAL_W-1:0]      hval_reg;
    logic [TIME_W-1:0]      now_reg;

    logic [CAPACITY-1:0]    valid_reg;
    logic [CAPACITY-1:0]    valid_next;
    slot_t                  newest_reg;
    slot_t                  newest_next;
    slot_t                  oldest_reg;
    slot_t                  oldest_next;
    cnt_t                   count_reg;
    cnt_t                   count_next;
    logic [PERIOD_W-1:0]    sample_reg;
    logic [PERIOD_W-1:0]    sample_next;
    logic [TIME_W-1:0]      last_reg;
    logic [TIME_W-1:0]      last_next;

    logic [SLOT_W:0]        scan_addr_reg;
    logic                   cmp_vld_reg;
    slot_t                  cmp_idx_reg;
    logic [ADDR_W-1:0]      key_rd_reg;
    logic                   match_found_reg;
    logic                   free_found_reg;
    slot_t                  match_slot_reg;
    slot_t                  free_slot_reg;
    slot_t                  tgt_reg;

    logic [HVAL_W-1:0]      hdl_rd_reg;
    slot_t                  newer_rd_reg;
    slot_t                  older_rd_reg;

    logic                   hit_reg;
    logic [HANDLE_BITS-1:0] fh_reg;
    logic                   fr_reg;
    logic                   flushed_reg;
    logic [PRUNED_W-1:0]    pruned_reg;
    logic [NPR_W-1:0]       n_reg;

    logic                   rsp_valid_reg;
    lac_rsp_t               rsp_data_reg;

    logic                   nw_we;
    slot_t                  nw_addr;
    slot_t                  nw_data;
    logic                   od_we;
    slot_t                  od_addr;
    slot_t                  od_data;

    logic                   scan_issue;
    logic                   cmp_v;
    logic                   cmp_hit;
    logic                   cmp_free;
    logic [TIME_W-1:0]      age;
    logic                   ttl_run;
    logic                   flush_now;
    logic                   is_new;
    logic                   is_old;
    logic [DIV_PROD_W-1:0]  prod;
    logic [NPR_W-1:0]       quot;
    logic [NPR_W-1:0]       n_init;

    assign scan_issue = cmd.scan_en && !scan_addr_reg[SLOT_W];
    assign cmp_v      = valid_reg[cmp_idx_reg];
    assign cmp_hit    = cmp_vld_reg && cmp_v && (key_rd_reg == ip_reg);
    assign cmp_free   = cmp_vld_reg && !cmp_v;
    assign age        = now_reg - last_reg;
    assign ttl_run    = cmd.ttl_check && (op_reg == OPC_LOOKUP)
                        && (sample_reg > sample_period);
    assign flush_now  = ttl_run && (age >= ttl_seconds);
    assign is_new     = (tgt_reg == newest_reg);
    assign is_old     = (tgt_reg == oldest_reg);
    assign prod       = DIV_PROD_W'({size_limit, 1'b0}) * DIV_PROD_W'(RECIP5);
    assign quot       = prod[RECIP_SHIFT +: NPR_W];
    assign n_init     = (quot == '0) ? NPR_W'(1) : quot;

    assign st.is_insert   = (op_reg == OPC_INSERT);
    assign st.scan_done   = scan_addr_reg[SLOT_W] && !cmp_vld_reg;
    assign st.match_found = match_found_reg;
    assign st.store_full  = (count_reg == CNT_W'(CAPACITY));
    assign st.prune_need  = (count_reg > CNT_W'(size_limit));
    assign st.prune_more  = (n_reg != '0) && (count_reg != '0);
    assign st.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        valid_next  = valid_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        nw_we       = 1'b0;
        nw_addr     = tgt_reg;
        nw_data     = tgt_reg;
        od_we       = 1'b0;
        od_addr     = tgt_reg;
        od_data     = newest_reg;
        if (cmd.ttl_check && (op_reg == OPC_LOOKUP))
        begin
            if (ttl_run)
            begin
                sample_next = '0;
            end
            else
            begin
                sample_next = sample_reg + 1'b1;
            end
        end
        if (flush_now)
        begin
            valid_next  = '0;
            newest_next = '0;
            oldest_next = '0;
            count_next  = '0;
            last_next   = now_reg;
        end
        if (cmd.unlink)
        begin
            if (is_new && is_old)
            begin
                newest_next = '0;
                oldest_next = '0;
            end
            else if (is_new)
            begin
                newest_next = older_rd_reg;
            end
            else if (is_old)
            begin
                oldest_next = newer_rd_reg;
            end
            else
            begin
                nw_we   = 1'b1;
                nw_addr = older_rd_reg;
                nw_data = newer_rd_reg;
                od_we   = 1'b1;
                od_addr = newer_rd_reg;
                od_data = older_rd_reg;
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
            if (cmd.clear_valid)
            begin
                valid_next[tgt_reg] = 1'b0;
            end
        end
        if (cmd.push)
        begin
            if (count_reg == '0)
            begin
                newest_next = tgt_reg;
                oldest_next = tgt_reg;
            end
            else
            begin
                nw_we       = 1'b1;
                nw_addr     = newest_reg;
                nw_data     = tgt_reg;
                od_we       = 1'b1;
                od_addr     = tgt_reg;
                od_data     = newest_reg;
                newest_next = tgt_reg;
            end
            count_next = count_reg + 1'b1;
            if (cmd.store_wr)
            begin
                valid_next[tgt_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            sample_reg <= '0;
            last_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            sample_reg <= sample_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            n_reg           <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_addr_reg   <= '0;
                cmp_vld_reg     <= 1'b0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                cmp_vld_reg <= scan_issue;
                if (cmp_hit)
                begin
                    match_found_reg <= 1'b1;
                end
                if (cmp_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.prune_init)
            begin
                n_reg <= n_init;
            end
            else if (cmd.n_dec)
            begin
                n_reg <= n_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            op_reg   <= req_data.opcode;
            ip_reg   <= req_data.ipv4_addr;
            hval_reg <= req_data.name_resolved ? {1'b1, req_data.host_handle} : '0;
            now_reg  <= req_data.now_seconds;
        end
        if (scan_issue)
        begin
            cmp_idx_reg <= scan_addr_reg[SLOT_W-1:0];
        end
        if (cmp_hit && !match_found_reg)
        begin
            match_slot_reg <= cmp_idx_reg;
        end
        if (cmp_free && !free_found_reg)
        begin
            free_slot_reg <= cmp_idx_reg;
        end
        case (cmd.tgt_sel)
            TGT_MATCH:  tgt_reg <= match_slot_reg;
            TGT_FREE:   tgt_reg <= free_slot_reg;
            TGT_OLDEST: tgt_reg <= oldest_reg;
            default:    tgt_reg <= tgt_reg;
        endcase
        if (cmd.op_load)
        begin
            hit_reg     <= 1'b0;
            fh_reg      <= '0;
            fr_reg      <= 1'b0;
            flushed_reg <= 1'b0;
            pruned_reg  <= '0;
        end
        else
        begin
            if (flush_now)
            begin
                flushed_reg <= 1'b1;
            end
            if (cmd.hit_latch)
            begin
                hit_reg <= 1'b1;
                fh_reg  <= hdl_rd_reg[HANDLE_BITS-1:0];
                fr_reg  <= hdl_rd_reg[HANDLE_BITS];
            end
            if (cmd.pruned_inc)
            begin
                pruned_reg <= pruned_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            rsp_data_reg.hit            <= hit_reg;
            rsp_data_reg.found_handle   <= fh_reg;
            rsp_data_reg.found_resolved <= fr_reg;
            rsp_data_reg.flushed        <= flushed_reg;
            rsp_data_reg.pruned_count   <= pruned_reg;
            rsp_data_reg.entry_count    <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            key_mem[tgt_reg] <= ip_reg;
        end
        if (scan_issue)
        begin
            key_rd_reg <= key_mem[scan_addr_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            hdl_mem[tgt_reg] <= hval_reg;
        end
        if (cmd.link_rd)
        begin
            hdl_rd_reg <= hdl_mem[tgt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nw_we)
        begin
            newer_mem[nw_addr] <= nw_data;
        end
        if (cmd.link_rd)
        begin
            newer_rd_reg <= newer_mem[tgt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (od_we)
        begin
            older_mem[od_addr] <= od_data;
        end
        if (cmd.link_rd)
        begin
            older_rd_reg <= older_mem[tgt_reg];
        end
    end

endmodule

// File: sv/lac_checker.sv
// ----------------------------------------------------------------------------
// lac_checker
// Port-level checks on the response channel of the cache.
// ----------------------------------------------------------------------------
module lac_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input lac_pkg::lac_rsp_t rsp_data
);
    import lac_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word dropped or changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.hit |->
            rsp_data.found_handle == '0 && rsp_data.found_resolved == 1'b0)
        else $error("handle reported without a hit");

    a_op_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.hit |->
            !rsp_data.flushed && rsp_data.pruned_count == '0)
        else $error("hit together with flush or prune");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.flushed |-> rsp_data.entry_count == '0)
        else $error("flush left entries behind");

endmodule

bind lru_address_name_cache lac_checker u_lac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
